### rtl/semaphore_blocked_queue_table_defines.svh
// Assertion macros for the semaphore queue table
`ifndef SEMAPHORE_BLOCKED_QUEUE_TABLE_DEFINES_SVH
`define SEMAPHORE_BLOCKED_QUEUE_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SBQT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SBQT_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define SBQT_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SBQT_ASSERT(label, cond, msg)
`define SBQT_ASSERT_IMP(label, pre, post, msg)
`define SBQT_ASSERT_NXT(label, pre, post, msg)
`endif

`endif

### rtl/sbqt_pkg.sv
package sbqt_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] status_t;
  typedef logic [4:0] pid_t;
  typedef logic [31:0] addr_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_OUT    = 2'd2;
  localparam opcode_t OP_PEEK   = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;

endpackage

### rtl/sbqt_if.sv
interface sbqt_req_if
  import sbqt_pkg::*;
();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  addr_t   sem_address;
  pid_t    process_id;

  modport source (output valid, output opcode, output sem_address, output process_id,
                  input ready);
  modport sink   (input valid, input opcode, input sem_address, input process_id,
                  output ready);
endinterface

interface sbqt_rsp_if
  import sbqt_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;
  logic    result_valid;
  pid_t    result_process;

  modport source (output valid, output status, output result_valid, output result_process,
                  input ready);
  modport sink   (input valid, input status, input result_valid, input result_process,
                  output ready);
endinterface

### rtl/semaphore_blocked_queue_table.sv
// Active semaphore table: up to MAX_PROCESSES semaphore descriptors, each with a FIFO of
// blocked process ids (insert, remove head, take out a given process, peek head). An item
// is taken into an input register, resolved there (address match over all descriptors,
// list pointer update) and written to a result register, so one item can be transferred
// every cycle while the result port is not stalled. The result register is loaded from
// the input register when it is empty or its result is taken in that same cycle.
// A stalled result holds the input register, which then holds the request port.
`include "semaphore_blocked_queue_table_defines.svh"

module semaphore_blocked_queue_table
  import sbqt_pkg::*;
#(
  parameter int MAX_PROCESSES = 32
) (
  input  logic       clk,
  input  logic       rst,
  sbqt_req_if.sink   req,
  sbqt_rsp_if.source rsp
);

  localparam int SW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  typedef logic [SW-1:0] idx_t;

  // input register
  logic    in_v;
  opcode_t op_q;
  addr_t   addr_q;
  pid_t    pid_q;

  // result register
  logic    out_v;
  status_t status_q;
  logic    rvalid_q;
  pid_t    rproc_q;

  // table state
  logic [MAX_PROCESSES-1:0] in_use, in_use_next;
  logic [MAX_PROCESSES-1:0] blocked, blocked_next;
  addr_t slot_address [MAX_PROCESSES];
  addr_t slot_address_next [MAX_PROCESSES];
  pid_t  head [MAX_PROCESSES];
  pid_t  head_next [MAX_PROCESSES];
  pid_t  tail [MAX_PROCESSES];
  pid_t  tail_next [MAX_PROCESSES];
  idx_t  owner [MAX_PROCESSES];
  idx_t  owner_next [MAX_PROCESSES];
  pid_t  next_link [MAX_PROCESSES];
  pid_t  next_link_next [MAX_PROCESSES];
  pid_t  prev_link [MAX_PROCESSES];
  pid_t  prev_link_next [MAX_PROCESSES];

  logic adv;
  assign adv       = in_v && (!out_v || rsp.ready);
  assign req.ready = !in_v || adv;

  // lookup
  logic [MAX_PROCESSES-1:0] match;
  logic    hit, free_any, pid_ok;
  idx_t    s_hit, s_free, pidx;

  always_comb begin
    s_hit  = '0;
    s_free = '0;
    for (int i = 0; i < MAX_PROCESSES; i++) begin
      match[i] = in_use[i] && (slot_address[i] == addr_q);
      if (match[i]) s_hit = s_hit | idx_t'(i);
    end
    for (int i = MAX_PROCESSES - 1; i >= 0; i--) begin
      if (!in_use[i]) s_free = idx_t'(i);
    end
  end

  assign hit      = |match;
  assign free_any = ~&in_use;
  assign pid_ok   = int'(pid_q) < MAX_PROCESSES;
  assign pidx     = idx_t'(pid_q);

  status_t st;
  logic    rv;
  pid_t    rp;
  logic    do_unlink, at_head, at_tail;
  idx_t    u_s, u_p, ins_s;
  pid_t    u_p5, nx, pv;

  always_comb begin
    st               = ST_OK;
    rv               = 1'b0;
    rp               = '0;
    do_unlink        = 1'b0;
    u_p5             = pid_q;
    u_s              = owner[pidx];
    ins_s            = s_hit;
    in_use_next      = in_use;
    blocked_next     = blocked;
    slot_address_next = slot_address;
    head_next        = head;
    tail_next        = tail;
    owner_next       = owner;
    next_link_next   = next_link;
    prev_link_next   = prev_link;

    unique case (op_q) inside
      OP_INSERT: begin
        if (!pid_ok) begin
          st = ST_NOTFOUND;
        end else if (!blocked[pidx]) begin
          if (hit) begin
            ins_s = s_hit;
            next_link_next[idx_t'(tail[s_hit])] = pid_q;
            prev_link_next[pidx] = tail[s_hit];
            tail_next[s_hit] = pid_q;
            blocked_next[pidx] = 1'b1;
            owner_next[pidx] = ins_s;
          end else if (free_any) begin
            ins_s = s_free;
            in_use_next[s_free] = 1'b1;
            slot_address_next[s_free] = addr_q;
            head_next[s_free] = pid_q;
            tail_next[s_free] = pid_q;
            blocked_next[pidx] = 1'b1;
            owner_next[pidx] = ins_s;
          end else begin
            st = ST_FULL;
          end
        end
      end
      OP_REMOVE, OP_PEEK: begin
        if (!hit) begin
          st = ST_NOTFOUND;
        end else begin
          rv = 1'b1;
          rp = head[s_hit];
          if (op_q == OP_REMOVE) begin
            do_unlink = 1'b1;
            u_p5 = head[s_hit];
            u_s  = s_hit;
          end
        end
      end
      default: begin
        if (!pid_ok || !blocked[pidx]) begin
          st = ST_NOTFOUND;
        end else begin
          rv = 1'b1;
          rp = pid_q;
          do_unlink = 1'b1;
        end
      end
    endcase

    u_p     = idx_t'(u_p5);
    nx      = next_link[u_p];
    pv      = prev_link[u_p];
    at_head = head[u_s] == u_p5;
    at_tail = tail[u_s] == u_p5;

    if (do_unlink) begin
      if (at_head && at_tail) begin
        in_use_next[u_s] = 1'b0;
      end else begin
        if (at_head) head_next[u_s] = nx;
        else         next_link_next[idx_t'(pv)] = nx;
        if (at_tail) tail_next[u_s] = pv;
        else         prev_link_next[idx_t'(nx)] = pv;
      end
      blocked_next[u_p] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v    <= 1'b0;
      out_v   <= 1'b0;
      in_use  <= '0;
      blocked <= '0;
    end else begin
      if (req.valid && req.ready) in_v <= 1'b1;
      else if (adv)               in_v <= 1'b0;
      if (adv)            out_v <= 1'b1;
      else if (rsp.ready) out_v <= 1'b0;
      if (adv) begin
        in_use  <= in_use_next;
        blocked <= blocked_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_q   <= req.opcode;
      addr_q <= req.sem_address;
      pid_q  <= req.process_id;
    end
    if (adv) begin
      status_q     <= st;
      rvalid_q     <= rv;
      rproc_q      <= rp;
      slot_address <= slot_address_next;
      head         <= head_next;
      tail         <= tail_next;
      owner        <= owner_next;
      next_link    <= next_link_next;
      prev_link    <= prev_link_next;
    end
  end

  assign rsp.valid          = out_v;
  assign rsp.status         = status_q;
  assign rsp.result_valid   = rvalid_q;
  assign rsp.result_process = rproc_q;

  `SBQT_ASSERT(a_unique_match, !in_v || $countones(match) <= 1, "address matches two slots")
  `SBQT_ASSERT(a_slot_has_proc, $countones(in_use) <= $countones(blocked), "empty slot in use")
  `SBQT_ASSERT_IMP(a_accept_full, req.valid && req.ready && in_v, adv, "input overrun")
  `SBQT_ASSERT_NXT(a_result_loaded, adv, out_v, "result not loaded")

endmodule
